/* rtl/matrix_inverse_3x3_core_assert.svh */
// Assertion macros for the 3x3 matrix inverse block.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef MATRIX_INVERSE_3X3_CORE_ASSERT_SVH
`define MATRIX_INVERSE_3X3_CORE_ASSERT_SVH

// Property that holds in the same cycle.
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define MI3_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/mi3_pkg.sv */
package mi3_pkg;

  // Fraction bits of the element format
  localparam int FRAC_BITS = 16;

  localparam int EW       = 32;                 // element width
  localparam int PW       = 2 * EW;             // product of two elements
  localparam int CW       = PW + 1;             // cofactor
  localparam int DW       = 3 * EW + 3;         // determinant
  localparam int RW       = DW;                 // divisor magnitude and remainder
  localparam int QW       = EW;                 // quotient bits kept
  localparam int NW       = PW + 2 * FRAC_BITS; // scaled cofactor magnitude
  localparam int NLANE    = 9;
  localparam int FRONT_ST = 6;
  localparam int DIV_ST   = QW + 1;
  localparam int NST      = FRONT_ST + DIV_ST + 1;

  typedef logic [EW-1:0] elem_w_t;
  typedef logic [NLANE-1:0][EW-1:0] mat_t;
  typedef logic [3:0] idx_t;

  // Element indices (row * 3 + col) of each cofactor: c = m[0]*m[1] - m[2]*m[3]
  localparam idx_t COF_TBL [NLANE][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5},
    '{4'd7, 4'd2, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd6, 4'd2},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  typedef struct packed {
    logic [NW-1:0] num;
    logic          neg;
  } lane_op_t;

  typedef struct packed {
    logic [QW-1:0] quo;
    logic          ovf;
    logic          neg;
  } lane_res_t;

endpackage

/* rtl/mi3_if.sv */
interface mi3_in_if;
  logic            valid;
  logic            ready;
  mi3_pkg::elem_w_t a00;
  mi3_pkg::elem_w_t a01;
  mi3_pkg::elem_w_t a02;
  mi3_pkg::elem_w_t a10;
  mi3_pkg::elem_w_t a11;
  mi3_pkg::elem_w_t a12;
  mi3_pkg::elem_w_t a20;
  mi3_pkg::elem_w_t a21;
  mi3_pkg::elem_w_t a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface mi3_out_if;
  logic            valid;
  logic            ready;
  mi3_pkg::elem_w_t r00;
  mi3_pkg::elem_w_t r01;
  mi3_pkg::elem_w_t r02;
  mi3_pkg::elem_w_t r10;
  mi3_pkg::elem_w_t r11;
  mi3_pkg::elem_w_t r12;
  mi3_pkg::elem_w_t r20;
  mi3_pkg::elem_w_t r21;
  mi3_pkg::elem_w_t r22;
  logic            singular;
  logic            saturated;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, saturated, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, saturated, output ready);
endinterface

/* rtl/mi3_front.sv */
module mi3_front (
  input  logic                                           clk_i,
  input  logic [mi3_pkg::FRONT_ST-1:0]                   en_i,
  input  mi3_pkg::mat_t                                  mat_i,
  output mi3_pkg::lane_op_t [mi3_pkg::NLANE-1:0]         op_o,
  output logic [mi3_pkg::RW-1:0]                         dmag_o,
  output logic                                           singular_o
);

  logic signed [mi3_pkg::PW-1:0]   pa_q [mi3_pkg::NLANE];
  logic signed [mi3_pkg::PW-1:0]   pb_q [mi3_pkg::NLANE];
  logic signed [mi3_pkg::CW-1:0]   c_q  [4][mi3_pkg::NLANE];
  logic [2:0][mi3_pkg::EW-1:0]     row_q [2];
  logic signed [2*mi3_pkg::EW:0]   lo_q [3];
  logic signed [2*mi3_pkg::EW:0]   hi_q [3];
  logic signed [mi3_pkg::DW-1:0]   col_q [3];
  logic signed [mi3_pkg::DW-1:0]   det_q;
  logic                            dneg;

  // Carry the top row along for the determinant expansion
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      row_q[0] <= mat_i[2:0];
    end
    if (en_i[1]) begin
      row_q[1] <= row_q[0];
    end
  end

  // Element products and cofactors, one lane each
  for (genvar k = 0; k < mi3_pkg::NLANE; k++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en_i[0]) begin
        pa_q[k] <= $signed(mat_i[mi3_pkg::COF_TBL[k][0]]) *
                   $signed(mat_i[mi3_pkg::COF_TBL[k][1]]);
        pb_q[k] <= $signed(mat_i[mi3_pkg::COF_TBL[k][2]]) *
                   $signed(mat_i[mi3_pkg::COF_TBL[k][3]]);
      end
      if (en_i[1]) begin
        c_q[0][k] <= mi3_pkg::CW'(pa_q[k]) - mi3_pkg::CW'(pb_q[k]);
      end
      if (en_i[2]) begin
        c_q[1][k] <= c_q[0][k];
      end
      if (en_i[3]) begin
        c_q[2][k] <= c_q[1][k];
      end
      if (en_i[4]) begin
        c_q[3][k] <= c_q[2][k];
      end
    end
  end

  // Determinant as top row times its cofactors, split into half products
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (en_i[2]) begin
        lo_q[j] <= $signed({1'b0, c_q[0][3*j][mi3_pkg::EW-1:0]}) * $signed(row_q[1][j]);
        hi_q[j] <= $signed(c_q[0][3*j][mi3_pkg::CW-1:mi3_pkg::EW]) * $signed(row_q[1][j]);
      end
      if (en_i[3]) begin
        col_q[j] <= (mi3_pkg::DW'(hi_q[j]) <<< mi3_pkg::EW) + mi3_pkg::DW'(lo_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      det_q <= col_q[0] + col_q[1] + col_q[2];
    end
  end

  // Magnitudes and signs for the dividers
  assign dneg = det_q[mi3_pkg::DW-1];

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      dmag_o     <= dneg ? mi3_pkg::RW'(-det_q) : mi3_pkg::RW'(det_q);
      singular_o <= (det_q == '0);
    end
  end

  for (genvar k = 0; k < mi3_pkg::NLANE; k++) begin : g_op
    logic signed [mi3_pkg::CW-1:0] cmag;

    assign cmag = c_q[3][k][mi3_pkg::CW-1] ? -c_q[3][k] : c_q[3][k];

    always_ff @(posedge clk_i) begin
      if (en_i[5]) begin
        op_o[k].num <= mi3_pkg::NW'(cmag[mi3_pkg::PW-1:0]) << (2 * mi3_pkg::FRAC_BITS);
        op_o[k].neg <= c_q[3][k][mi3_pkg::CW-1] ^ dneg;
      end
    end
  end

endmodule

/* rtl/mi3_div_lane.sv */
module mi3_div_lane (
  input  logic                                          clk_i,
  input  logic [mi3_pkg::DIV_ST-1:0]                    en_i,
  input  mi3_pkg::lane_op_t                             op_i,
  input  logic [mi3_pkg::DIV_ST-1:0][mi3_pkg::RW-1:0]   dmag_i,
  output mi3_pkg::lane_res_t                            res_o
);

  localparam int LAST = mi3_pkg::DIV_ST - 1;

  logic [mi3_pkg::RW-1:0] rem_q [mi3_pkg::DIV_ST];
  logic [mi3_pkg::QW-1:0] nlo_q [mi3_pkg::DIV_ST];
  logic [mi3_pkg::QW-1:0] quo_q [mi3_pkg::DIV_ST];
  logic                   ovf_q [mi3_pkg::DIV_ST];
  logic                   neg_q [mi3_pkg::DIV_ST];
  logic [mi3_pkg::RW-1:0] top;

  // Check range: quotient fits in QW bits only if the top part is below the divisor
  assign top = mi3_pkg::RW'(op_i.num[mi3_pkg::NW-1:mi3_pkg::QW]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= top;
      ovf_q[0] <= (top >= dmag_i[0]);
      nlo_q[0] <= op_i.num[mi3_pkg::QW-1:0];
      quo_q[0] <= '0;
      neg_q[0] <= op_i.neg;
    end
  end

  // One restoring quotient bit per stage
  for (genvar s = 1; s < mi3_pkg::DIV_ST; s++) begin : g_step
    logic [mi3_pkg::RW:0] trial;
    logic [mi3_pkg::RW:0] diff;
    logic                 take;

    assign trial = {rem_q[s-1], nlo_q[s-1][mi3_pkg::QW-1]};
    assign diff  = trial - {1'b0, dmag_i[s]};
    assign take  = (trial >= {1'b0, dmag_i[s]});

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= take ? diff[mi3_pkg::RW-1:0] : trial[mi3_pkg::RW-1:0];
        nlo_q[s] <= nlo_q[s-1] << 1;
        quo_q[s] <= {quo_q[s-1][mi3_pkg::QW-2:0], take};
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign res_o.quo = quo_q[LAST];
  assign res_o.ovf = ovf_q[LAST];
  assign res_o.neg = neg_q[LAST];

endmodule

/* rtl/mi3_merge.sv */
module mi3_merge (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  mi3_pkg::lane_res_t [mi3_pkg::NLANE-1:0] res_i,
  input  logic                                    singular_i,
  output mi3_pkg::mat_t                           r_o,
  output logic                                    singular_o,
  output logic                                    saturated_o
);

  logic [mi3_pkg::NLANE-1:0] sat;
  mi3_pkg::mat_t             val;

  // Clip each lane to its signed limit and apply the sign
  for (genvar k = 0; k < mi3_pkg::NLANE; k++) begin : g_lane
    logic [mi3_pkg::QW-1:0] lim;
    logic [mi3_pkg::QW-1:0] mag;

    assign lim    = {res_i[k].neg, {(mi3_pkg::QW-1){~res_i[k].neg}}};
    assign sat[k] = res_i[k].ovf || (res_i[k].quo > lim);
    assign mag    = sat[k] ? lim : res_i[k].quo;
    assign val[k] = res_i[k].neg ? -mag : mag;
  end

  // Output register; zero everything on a singular matrix
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o         <= singular_i ? '0 : val;
      singular_o  <= singular_i;
      saturated_o <= !singular_i && (|sat);
    end
  end

endmodule

/* rtl/matrix_inverse_3x3_core.sv */
// 3x3 matrix inverse by the adjugate in signed Q16.16. One matrix is taken
// per clock unless a stalled output has filled all stages; each result
// passes 40 register stages: six front stages form the cofactors and the
// determinant, nine dividers run side by side with one quotient bit per
// stage (33 stages each, the first checking range), and a final register
// clips, signs and flags the nine elements. Each stage holds its item until
// the next stage can take it, so the block keeps accepting matrices while a
// result waits at the output until all stages are full. A zero determinant
// gives all-zero elements with singular set.
module matrix_inverse_3x3_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mi3_in_if.sink    in_i,
  mi3_out_if.source out_o
);

  localparam int NST = mi3_pkg::NST;
  localparam int FST = mi3_pkg::FRONT_ST;
  localparam int DST = mi3_pkg::DIV_ST;

  logic [NST-1:0]                                  vld_q;
  logic [NST-1:0]                                  en;
  mi3_pkg::mat_t                                   mat;
  mi3_pkg::mat_t                                   res_mat;
  mi3_pkg::lane_op_t [mi3_pkg::NLANE-1:0]          op;
  mi3_pkg::lane_res_t [mi3_pkg::NLANE-1:0]         lres;
  logic [mi3_pkg::RW-1:0]                          dmag;
  logic                                            sing;
  logic [DST-1:0][mi3_pkg::RW-1:0]                 dv_in;
  logic [mi3_pkg::RW-1:0]                          dv_q [DST-1];
  logic [DST-1:0]                                  sing_q;

  // Stage enables: a stage loads when it is empty or its successor loads
  assign en[NST-1] = !vld_q[NST-1] || out_o.ready;
  for (genvar s = 0; s < NST - 1; s++) begin : g_en
    assign en[s] = !vld_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = vld_q[NST-1];

  assign mat = {in_i.a22, in_i.a21, in_i.a20, in_i.a12, in_i.a11, in_i.a10,
                in_i.a02, in_i.a01, in_i.a00};

  mi3_front u_front (
    .clk_i      (clk_i),
    .en_i       (en[FST-1:0]),
    .mat_i      (mat),
    .op_o       (op),
    .dmag_o     (dmag),
    .singular_o (sing)
  );

  // Shared divisor and singular flag, kept in step with the divider stages
  always_ff @(posedge clk_i) begin
    if (en[FST]) begin
      dv_q[0]   <= dmag;
      sing_q[0] <= sing;
    end
    for (int s = 1; s < DST - 1; s++) begin
      if (en[FST+s]) begin
        dv_q[s] <= dv_q[s-1];
      end
    end
    for (int s = 1; s < DST; s++) begin
      if (en[FST+s]) begin
        sing_q[s] <= sing_q[s-1];
      end
    end
  end

  assign dv_in[0] = dmag;
  for (genvar s = 1; s < DST; s++) begin : g_dv
    assign dv_in[s] = dv_q[s-1];
  end

  for (genvar k = 0; k < mi3_pkg::NLANE; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[FST+DST-1:FST]),
      .op_i   (op[k]),
      .dmag_i (dv_in),
      .res_o  (lres[k])
    );
  end

  mi3_merge u_merge (
    .clk_i       (clk_i),
    .en_i        (en[NST-1]),
    .res_i       (lres),
    .singular_i  (sing_q[DST-1]),
    .r_o         (res_mat),
    .singular_o  (out_o.singular),
    .saturated_o (out_o.saturated)
  );

  assign out_o.r00 = res_mat[0];
  assign out_o.r01 = res_mat[1];
  assign out_o.r02 = res_mat[2];
  assign out_o.r10 = res_mat[3];
  assign out_o.r11 = res_mat[4];
  assign out_o.r12 = res_mat[5];
  assign out_o.r20 = res_mat[6];
  assign out_o.r21 = res_mat[7];
  assign out_o.r22 = res_mat[8];

endmodule

/* rtl/mi3_checker.sv */
`include "matrix_inverse_3x3_core_assert.svh"

module mi3_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input mi3_pkg::mat_t r_i,
  input logic          singular_i,
  input logic          saturated_i
);

  logic [mi3_pkg::NLANE-1:0] at_limit;

  // Flag elements sitting on either end of the signed range
  for (genvar k = 0; k < mi3_pkg::NLANE; k++) begin : g_lim
    assign at_limit[k] = (r_i[k] == {1'b0, {(mi3_pkg::EW-1){1'b1}}}) ||
                         (r_i[k] == {1'b1, {(mi3_pkg::EW-1){1'b0}}});
  end

  `MI3_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `MI3_ASSERT(a_stall_cause, !in_ready_i |-> (out_valid_i && !out_ready_i), "input stalled without output back-pressure")
  `MI3_ASSERT(a_singular_zero, (out_valid_i && singular_i) |-> (r_i == '0 && !saturated_i), "singular result not cleared")
  `MI3_ASSERT(a_sat_limit, (out_valid_i && saturated_i) |-> (|at_limit), "saturated flag without a clipped element")

endmodule

bind matrix_inverse_3x3_core mi3_checker u_mi3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .r_i         ({out_o.r22, out_o.r21, out_o.r20, out_o.r12, out_o.r11, out_o.r10,
                 out_o.r02, out_o.r01, out_o.r00}),
  .singular_i  (out_o.singular),
  .saturated_i (out_o.saturated)
);

/* tb/matrix_inverse_3x3_core_tb.sv */
module matrix_inverse_3x3_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM   = 880;
  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 80;

  typedef logic signed [31:0] elem_t;

  typedef struct {
    elem_t a [9];
  } matrix_t;

  typedef struct {
    elem_t r [9];
    logic  singular;
    logic  saturated;
  } inverse_t;

  logic clk_i;
  logic rst_ni;

  mi3_in_if  mat_in ();
  mi3_out_if inv_out ();

  matrix_inverse_3x3_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (mat_in),
    .out_o  (inv_out)
  );

  matrix_t  matrix_q [$];
  inverse_t inverse_q [$];

  int  n_sent;
  int  n_checked;
  int  n_singular;
  int  n_saturated;
  int  n_mismatch;
  int  idle_cycles;
  bit  in_taken;
  bit  long_hold_done;
  bit  stimulus_done;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Cofactor of element indices: m[p]*m[q] - m[s]*m[t]
  function automatic logic signed [127:0] cofactor(matrix_t m, int p, int q, int s, int t);
    logic signed [127:0] ep, eq, es, et;
    ep = m.a[p];
    eq = m.a[q];
    es = m.a[s];
    et = m.a[t];
    return ep * eq - es * et;
  endfunction

  // Expected inverse of one matrix, by the adjugate over the determinant
  function automatic inverse_t invert(matrix_t m);
    inverse_t            res;
    logic signed [127:0] e [9];
    logic signed [127:0] det;
    logic signed [127:0] cof [9];
    logic [127:0]        dmag, nmag, quo, lim;
    logic                neg;
    for (int k = 0; k < 9; k++) e[k] = m.a[k];
    det = e[0] * e[4] * e[8] + e[1] * e[5] * e[6] + e[2] * e[3] * e[7]
        - e[0] * e[5] * e[7] - e[1] * e[3] * e[8] - e[2] * e[4] * e[6];
    res.singular  = 1'b0;
    res.saturated = 1'b0;
    for (int k = 0; k < 9; k++) res.r[k] = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    cof[0] = cofactor(m, 4, 8, 7, 5);
    cof[1] = cofactor(m, 7, 2, 1, 8);
    cof[2] = cofactor(m, 1, 5, 4, 2);
    cof[3] = cofactor(m, 6, 5, 3, 8);
    cof[4] = cofactor(m, 0, 8, 6, 2);
    cof[5] = cofactor(m, 3, 2, 0, 5);
    cof[6] = cofactor(m, 3, 7, 6, 4);
    cof[7] = cofactor(m, 6, 1, 0, 7);
    cof[8] = cofactor(m, 0, 4, 3, 1);
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < 9; k++) begin
      neg  = (cof[k] < 0) != (det < 0);
      nmag = ((cof[k] < 0) ? -cof[k] : cof[k]);
      nmag = nmag << (2 * mi3_pkg::FRAC_BITS);
      quo  = nmag / dmag;
      lim  = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (quo > lim) begin
        quo = lim;
        res.saturated = 1'b1;
      end
      res.r[k] = neg ? elem_t'(-quo[31:0]) : elem_t'(quo[31:0]);
    end
    return res;
  endfunction

  function automatic elem_t pick_extreme();
    case ($urandom_range(0, 6))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return 32'sd1;
      4:       return -32'sd1;
      5:       return 32'sd65536;
      default: return -32'sd65536;
    endcase
  endfunction

  function automatic matrix_t diag(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int k = 0; k < 9; k++) m.a[k] = '0;
    m.a[0] = d0;
    m.a[4] = d1;
    m.a[8] = d2;
    return m;
  endfunction

  function automatic matrix_t all_of(elem_t v);
    matrix_t m;
    for (int k = 0; k < 9; k++) m.a[k] = v;
    return m;
  endfunction

  // Random matrix of a chosen flavour
  function automatic matrix_t random_matrix();
    matrix_t m;
    int      kind;
    kind = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++) begin
      if (kind < 50)      m.a[k] = $signed($urandom_range(0, 524288)) - 262144;
      else if (kind < 65) m.a[k] = $urandom;
      else if (kind < 80) m.a[k] = $signed($urandom_range(0, 262144)) - 131072;
      else if (kind < 90) m.a[k] = $signed($urandom_range(0, 32)) - 16;
      else                m.a[k] = pick_extreme();
    end
    // make the third row a copy of the first for a singular matrix
    if (kind >= 65 && kind < 80) begin
      for (int k = 0; k < 3; k++) m.a[6 + k] = m.a[k];
    end
    return m;
  endfunction

  // Stimulus: directed matrices, then random ones
  initial begin
    matrix_t m;
    matrix_q.push_back(diag(32'sd65536, 32'sd65536, 32'sd65536));
    matrix_q.push_back(all_of(32'sd0));
    matrix_q.push_back(all_of(32'sh7FFF_FFFF));
    matrix_q.push_back(all_of(32'sh8000_0000));
    matrix_q.push_back(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    matrix_q.push_back(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    matrix_q.push_back(diag(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    matrix_q.push_back(diag(32'sd1, 32'sd1, 32'sd1));
    matrix_q.push_back(diag(-32'sd1, 32'sd1, 32'sd1));
    matrix_q.push_back(diag(32'sd131072, -32'sd65536, 32'sd32768));
    matrix_q.push_back(diag(32'sd65536, 32'sd65536, 32'sd0));
    // permutation matrix: negative determinant, some zero cofactors
    m = all_of(32'sd0);
    m.a[1] = 32'sd65536;
    m.a[3] = 32'sd65536;
    m.a[8] = 32'sd65536;
    matrix_q.push_back(m);
    // dense well-conditioned matrix
    m.a = '{32'sd131072, 32'sd65536, 32'sd0, 32'sd65536, 32'sd196608,
            32'sd65536, 32'sd0, 32'sd65536, 32'sd262144};
    matrix_q.push_back(m);
    // near-singular: tiny determinant, large quotients
    m.a = '{32'sd65536, 32'sd65536, 32'sd0, 32'sd65536, 32'sd65537,
            32'sd0, 32'sd0, 32'sd0, 32'sd65536};
    matrix_q.push_back(m);
    // alternating sign extremes
    m.a = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1, 32'sd0};
    matrix_q.push_back(m);
    m.a = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sd3, 32'sd7, 32'sh5555_5555,
            32'shAAAA_AAAA, 32'shFFFF_0000, 32'sh0000_FFFF, 32'sd12345};
    matrix_q.push_back(m);
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 9; k++) m.a[k] = pick_extreme();
      matrix_q.push_back(m);
    end
    for (int i = 0; i < NUM_RANDOM; i++) matrix_q.push_back(random_matrix());
    stimulus_done = 1'b1;
  end

  initial begin
    mat_in.valid = 1'b0;
    mat_in.a00 = '0; mat_in.a01 = '0; mat_in.a02 = '0;
    mat_in.a10 = '0; mat_in.a11 = '0; mat_in.a12 = '0;
    mat_in.a20 = '0; mat_in.a21 = '0; mat_in.a22 = '0;
    inv_out.ready = 1'b0;
  end

  // Sender: bursts of matrices separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    matrix_t m;
    if (rst_ni && (!mat_in.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        mat_in.valid <= 1'b0;
      end else if (matrix_q.size() != 0) begin
        m = matrix_q.pop_front();
        mat_in.a00 <= m.a[0]; mat_in.a01 <= m.a[1]; mat_in.a02 <= m.a[2];
        mat_in.a10 <= m.a[3]; mat_in.a11 <= m.a[4]; mat_in.a12 <= m.a[5];
        mat_in.a20 <= m.a[6]; mat_in.a21 <= m.a[7]; mat_in.a22 <= m.a[8];
        mat_in.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        mat_in.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls in some windows, free flow in others, one long hold
  int hold_left   = 0;
  int stall_phase = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_phase = (stall_phase + 1) % 512;
      if (!long_hold_done && n_sent >= 300) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        inv_out.ready <= 1'b0;
      end else if (stall_phase < 160) begin
        inv_out.ready <= 1'b1;
      end else begin
        inv_out.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Predict on each accepted matrix, check each accepted inverse
  always @(posedge clk_i) begin
    matrix_t  m;
    inverse_t want;
    inverse_t got;
    bit       bad;
    in_taken = 1'b0;
    if (rst_ni) begin
      idle_cycles++;
      if (mat_in.valid && mat_in.ready) begin
        in_taken = 1'b1;
        m.a = '{mat_in.a00, mat_in.a01, mat_in.a02, mat_in.a10, mat_in.a11,
                mat_in.a12, mat_in.a20, mat_in.a21, mat_in.a22};
        inverse_q.push_back(invert(m));
        n_sent++;
        idle_cycles = 0;
      end
      if (inv_out.valid && inv_out.ready) begin
        idle_cycles = 0;
        got.r = '{inv_out.r00, inv_out.r01, inv_out.r02, inv_out.r10, inv_out.r11,
                  inv_out.r12, inv_out.r20, inv_out.r21, inv_out.r22};
        got.singular  = inv_out.singular;
        got.saturated = inv_out.saturated;
        if (inverse_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("ERROR: inverse item with none expected");
        end else begin
          want = inverse_q.pop_front();
          bad  = (got.singular !== want.singular) || (got.saturated !== want.saturated);
          for (int k = 0; k < 9; k++) if (got.r[k] !== want.r[k]) bad = 1'b1;
          if (bad) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("ERROR: item %0d: expected sing=%b sat=%b got sing=%b sat=%b",
                       n_checked, want.singular, want.saturated,
                       got.singular, got.saturated);
              for (int k = 0; k < 9; k++)
                $display("  r%0d%0d expected %h got %h", k / 3, k % 3,
                         want.r[k], got.r[k]);
            end
          end
          n_singular  += want.singular;
          n_saturated += want.saturated;
        end
        n_checked++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles", IDLE_LIMIT);
        $display("matrix_inverse_3x3_core_tb NOT OK");
        $finish;
      end
    end
  end

  // Drain and report
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (!stimulus_done || matrix_q.size() != 0 || mat_in.valid ||
           inverse_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d inverses of %0d matrices: %0d singular, %0d saturated.",
             n_checked, n_sent, n_singular, n_saturated);
    $display("Sender bursts and gaps, receiver stalls and one long hold of %0d cycles.",
             LONG_HOLD);
    if (n_mismatch == 0 && inverse_q.size() == 0) begin
      $display("matrix_inverse_3x3_core_tb OK");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("matrix_inverse_3x3_core_tb NOT OK");
    end
    $finish;
  end

endmodule
